>>> rtl/htbd_pkg.sv
// Shared types and constants of the Huffman tree byte decoder.
package htbd_pkg;

  // Tree table geometry
  localparam int TREE_ENTRIES = 1024;
  localparam int TREE_AW      = $clog2(TREE_ENTRIES);
  localparam int OFF_W        = TREE_AW - 1;
  localparam int PAIRS        = TREE_ENTRIES / 2;

  localparam logic [15:0] ROOT_NODE = 16'h0100;
  localparam logic [15:0] LEAF_MAX  = 16'h00FF;

  localparam int BITS  = 8;
  localparam int BIT_W = $clog2(BITS);

  // Input commands
  localparam logic [1:0] CMD_LOAD    = 2'd0;
  localparam logic [1:0] CMD_BYTE    = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;

  // Operations handed from the front to the walker
  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_BYTE    = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  localparam int QUEUE_DEPTH = 2;
  localparam int Q_AW        = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [1:0]  cmd;
    logic [9:0]  entry_index;
    logic [15:0] entry_value;
    logic [7:0]  data_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] character;
    logic       end_of_string;
    logic       bad_node;
    logic       last_of_item;
  } result_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [TREE_AW-1:0] index;
    logic [15:0]        value;
    logic [7:0]         data;
  } op_t;

endpackage

>>> rtl/huffman_tree_byte_decoder.sv
// Top level of the Huffman tree byte decoder.
//
// Items arrive on item_valid/item_ready/item; a beat carries a command: load a
// tree word, decode one compressed byte (least significant bit first), or
// restart the string at the root. Decoded characters leave on
// result_valid/result_ready/result, zero to eight beats per byte, the last one
// flagged with last_of_item; a terminator or bad node sets end_of_string.
// A two-entry queue separates intake from the walker, so items keep coming in
// while the walker or the receiver stalls, until the queue is full.
// A byte is walked bit by bit after a start step, each bit waiting on the
// dependent read of the registered tree memory; a load or restart needs no
// walk. A result passes through the pending register into the output
// register; it is held pending until the next result or the end of the byte
// fixes last_of_item.
// Reset returns the walk to the root and clears the string-done flag; the tree
// memory keeps no reset value and must be loaded before use. While result_ready
// is low, a valid output register holds and the walker stalls while a result is pending.
module huffman_tree_byte_decoder import htbd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  logic op_valid;
  logic op_ready;
  op_t  op;

  htbd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .op_valid   (op_valid),
    .op_ready   (op_ready),
    .op         (op)
  );

  htbd_walk u_walk (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (op_valid),
    .op_ready  (op_ready),
    .op        (op),
    .res_valid (result_valid),
    .res_ready (result_ready),
    .res       (result)
  );

endmodule

>>> rtl/htbd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module htbd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/htbd_front.sv
// Input side: accept items, drop unused commands, queue operations for the walker.
module htbd_front import htbd_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  item_valid,
  output logic  item_ready,
  input  item_t item,
  output logic  op_valid,
  input  logic  op_ready,
  output op_t   op
);

  op_t             q [QUEUE_DEPTH];
  logic [Q_AW-1:0] wptr;
  logic [Q_AW-1:0] rptr;
  logic [Q_AW:0]   count;

  logic keep;
  op_t  op_in;
  logic push;
  logic pop;

  always_comb begin
    op_in.kind  = OP_LOAD;
    op_in.index = item.entry_index[TREE_AW-1:0];
    op_in.value = item.entry_value;
    op_in.data  = item.data_byte;
    keep        = 1'b0;
    unique case (item.cmd)
      CMD_LOAD: begin
        op_in.kind = OP_LOAD;
        keep       = 32'(item.entry_index) < TREE_ENTRIES;
      end
      CMD_BYTE: begin
        op_in.kind = OP_BYTE;
        keep       = 1'b1;
      end
      CMD_RESTART: begin
        op_in.kind = OP_RESTART;
        keep       = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign item_ready = count < (Q_AW+1)'(QUEUE_DEPTH);
  assign push       = item_valid && item_ready && keep;
  assign op_valid   = count != '0;
  assign pop        = op_valid && op_ready;
  assign op         = q[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == Q_AW'(QUEUE_DEPTH-1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == Q_AW'(QUEUE_DEPTH-1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wptr] <= op_in;
    end
  end

endmodule

>>> rtl/htbd_walk.sv
// Back side: tree memory, bit-serial tree walk and result staging.
module htbd_walk import htbd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    op_valid,
  output logic    op_ready,
  input  op_t     op,
  output logic    res_valid,
  input  logic    res_ready,
  output result_t res
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WALK = 1'b1;

  logic             state, state_next;
  logic [OFF_W-1:0] node_off, node_off_next;
  logic             done, done_next;
  logic [BIT_W-1:0] bidx, bidx_next, bidx_inc;
  logic [7:0]       byte_r;

  logic               we, re;
  logic [TREE_AW-1:0] raddr;
  logic [15:0]        rdata;

  logic             is_leaf, node_ok;
  logic [16:0]      off_full;
  logic [OFF_W-1:0] child_off;
  logic             has_res, res_eos, res_bad, walk_end;
  logic             out_free, can_step, step_res, pend_move, start;

  logic       pend_v, pend_v_next, pend_final, pend_final_next;
  logic [7:0] pend_ch;
  logic       pend_eos, pend_bad;

  htbd_ram #(.WIDTH(16), .DEPTH(TREE_ENTRIES)) u_tree (
    .clk   (clk),
    .we    (we),
    .waddr (op.index),
    .wdata (op.value),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Classify the child just read
  assign is_leaf   = rdata <= LEAF_MAX;
  assign off_full  = {1'b0, rdata} - {1'b0, ROOT_NODE};
  assign node_ok   = !is_leaf && (off_full < 17'(PAIRS));
  assign child_off = node_ok ? off_full[OFF_W-1:0] : '0;
  assign res_bad   = !is_leaf && !node_ok;
  assign res_eos   = res_bad || (is_leaf && rdata[7:0] == 8'h00);
  assign has_res   = is_leaf || res_bad;
  assign walk_end  = res_eos || (bidx == BIT_W'(BITS-1));
  assign bidx_inc  = bidx + 1'b1;

  assign out_free  = !res_valid || res_ready;
  assign can_step  = (state == ST_WALK) && (!pend_v || out_free);
  assign step_res  = can_step && has_res;
  // A pending result leaves once its last flag is known
  assign pend_move = pend_v && out_free && (pend_final || step_res);

  assign op_ready = state == ST_IDLE;
  assign start    = (state == ST_IDLE) && op_valid && (op.kind == OP_BYTE) && !done;
  assign we       = (state == ST_IDLE) && op_valid && (op.kind == OP_LOAD);

  always_comb begin
    state_next    = state;
    node_off_next = node_off;
    done_next     = done;
    bidx_next     = bidx;
    re            = 1'b0;
    raddr         = {node_off, op.data[0]};
    if (state == ST_IDLE) begin
      if (op_valid) begin
        unique case (op.kind)
          OP_RESTART: begin
            node_off_next = '0;
            done_next     = 1'b0;
          end
          OP_BYTE: begin
            if (!done) begin
              re         = 1'b1;
              state_next = ST_WALK;
              bidx_next  = '0;
            end
          end
          default: begin
          end
        endcase
      end
    end else if (can_step) begin
      node_off_next = child_off;
      if (res_eos) begin
        done_next = 1'b1;
      end
      if (walk_end) begin
        state_next = ST_IDLE;
      end else begin
        re        = 1'b1;
        raddr     = {child_off, byte_r[bidx_inc]};
        bidx_next = bidx_inc;
      end
    end
  end

  always_comb begin
    pend_v_next     = pend_v;
    pend_final_next = pend_final;
    if (pend_move) begin
      pend_v_next = 1'b0;
    end
    if (step_res) begin
      pend_v_next     = 1'b1;
      pend_final_next = walk_end;
    end else if (can_step && walk_end) begin
      pend_final_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      node_off   <= '0;
      done       <= 1'b0;
      bidx       <= '0;
      pend_v     <= 1'b0;
      pend_final <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      node_off   <= node_off_next;
      done       <= done_next;
      bidx       <= bidx_next;
      pend_v     <= pend_v_next;
      pend_final <= pend_final_next;
      if (pend_move) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      byte_r <= op.data;
    end
    if (step_res) begin
      pend_ch  <= is_leaf ? rdata[7:0] : 8'h00;
      pend_eos <= res_eos;
      pend_bad <= res_bad;
    end
    if (pend_move) begin
      res.character     <= pend_ch;
      res.end_of_string <= pend_eos;
      res.bad_node      <= pend_bad;
      res.last_of_item  <= pend_final;
    end
  end

  a_displace: assert property (@(posedge clk) disable iff (rst)
    (step_res && pend_v) |-> pend_move)
    else $error("new result arrived while pending result could not leave");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == ST_IDLE))
    else $error("walk running after string end");

  a_start: assert property (@(posedge clk) disable iff (rst)
    start |=> (state == ST_WALK && bidx == '0))
    else $error("walk did not start at bit zero");

  a_open_pend: assert property (@(posedge clk) disable iff (rst)
    (pend_v && !pend_final) |-> (state == ST_WALK))
    else $error("pending result without a final flag outside a walk");

endmodule
